// ----- design/assert_macros.svh -----
// Assertion helpers, included by the top-k selector unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Clocked assertion that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- design/tks_pkg.sv -----
`default_nettype none
package tks_pkg;

	// width of a reported position
	localparam int POS_W = 16;

	// per-cycle command to every cell of the chain
	typedef struct packed {
		logic insert;   // new key enters the sorted chain
		logic drain;    // contents move one cell toward the head
	} cell_ctl_t;

endpackage
`default_nettype wire

// ----- design/tks_cell.sv -----
`default_nettype none
// One slot of the sorted chain: holds a key and its position.
module tks_cell #(
	parameter int KEY_W = 32,
	parameter bit IS_HEAD = 1'b0
) (
	input  wire                        clk,
	input  wire tks_pkg::cell_ctl_t    ctl,
	input  wire                        slot_valid,
	input  wire  [KEY_W-1:0]           new_key,
	input  wire  [tks_pkg::POS_W-1:0]  new_pos,
	input  wire  [KEY_W-1:0]           prev_key,
	input  wire  [tks_pkg::POS_W-1:0]  prev_pos,
	input  wire                        prev_gt,
	input  wire  [KEY_W-1:0]           next_key,
	input  wire  [tks_pkg::POS_W-1:0]  next_pos,
	output logic [KEY_W-1:0]           key,
	output logic [tks_pkg::POS_W-1:0]  pos,
	output logic                       gt
);

	logic [KEY_W-1:0]          key_q;
	logic [tks_pkg::POS_W-1:0] pos_q;
	logic                      take_new;

	// new key wins over an empty slot or a strictly smaller key; ties stay put
	assign gt       = !slot_valid || (new_key > key_q);
	assign take_new = IS_HEAD || !prev_gt;

	// payload, no reset needed
	always_ff @(posedge clk) begin
		if (ctl.insert && gt) begin
			if (take_new) begin
				key_q <= new_key;
				pos_q <= new_pos;
			end else begin
				key_q <= prev_key;
				pos_q <= prev_pos;
			end
		end else if (ctl.drain) begin
			key_q <= next_key;
			pos_q <= next_pos;
		end
	end

	assign key = key_q;
	assign pos = pos_q;

endmodule
`default_nettype wire

// ----- design/top_k_score_selector_unit.sv -----
`default_nettype none
// Streaming top-k selector.
// Input channel (in_valid/in_ready) carries one score per beat, with end_of_run on
// the final score of a run. Scores are numbered 0, 1, 2, ... within a run; the
// K_MAX best are kept in a chain of cells sorted high to low, ties to the earlier.
// Throughput: one score per cycle while a run streams in; every cell compares
// the broadcast key with its own and shifts as the score is taken.
// After the end_of_run beat, min(k_count, scores kept) positions leave on the
// output channel (out_valid/out_ready), best first, final_result on the last and
// overflow on all of them if scores past N_MAX were dropped. Once the end_of_run
// beat starts the drain, a position is loaded into the output register whenever
// it is free; the chain then shifts toward its head one cell per output beat, and
// in_ready stays low until the last position is loaded into the output register.
// A stalled receiver holds the output register and the drain waits with it.
// cfg_we writes k_count (0 acts as 1, above K_MAX as K_MAX); write it only while
// idle. Reset clears the run state and output valid and sets k_count to 1.
module top_k_score_selector_unit #(
	parameter int K_MAX      = 16,
	parameter int N_MAX      = 65536,
	parameter int SCORE_BITS = 32
) (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [4:0]                  cfg_wdata,
	input  wire                         in_valid,
	output logic                        in_ready,
	input  wire  signed [SCORE_BITS-1:0] score,
	input  wire                         end_of_run,
	output logic                        out_valid,
	input  wire                         out_ready,
	output logic [tks_pkg::POS_W-1:0]   position,
	output logic                        final_result,
	output logic                        overflow
);

	`include "assert_macros.svh"

	localparam int FW = $clog2(K_MAX + 1);
	localparam int SW = $clog2(N_MAX + 1);
	localparam int KW = (FW > 5) ? FW : 5;

	logic [4:0]                 k_count_q;
	logic [FW-1:0]              filled_q;
	logic [SW-1:0]              seen_q;
	logic                       dropped_q;
	logic                       draining_q;
	logic [FW-1:0]              remain_q;
	logic                       run_ovf_q;
	logic                       out_valid_q;
	logic [tks_pkg::POS_W-1:0]  position_q;
	logic                       final_q;
	logic                       overflow_q;

	logic                       accept;
	logic                       take_score;
	logic                       out_free;
	logic                       drain_shift;
	logic [SCORE_BITS-1:0]      new_key;
	logic [tks_pkg::POS_W-1:0]  new_pos;
	logic [FW-1:0]              filled_next;
	logic                       dropped_next;
	logic [KW-1:0]              k_raw;
	logic [KW-1:0]              k_eff;
	logic [KW-1:0]              fill_ext;
	logic [KW-1:0]              n_out;
	tks_pkg::cell_ctl_t         ctl;

	logic [SCORE_BITS-1:0]      key_w [K_MAX];
	logic [tks_pkg::POS_W-1:0]  pos_w [K_MAX];
	logic                       gt_w  [K_MAX];

	// handshake and chain command
	assign in_ready    = !draining_q;
	assign accept      = in_valid && in_ready;
	assign take_score  = accept && (seen_q < SW'(N_MAX));
	assign out_free    = !out_valid_q || out_ready;
	assign drain_shift = draining_q && out_free;
	assign ctl         = '{insert: take_score, drain: drain_shift};

	// inverted sign bit makes unsigned compare follow signed order
	assign new_key = score ^ {1'b1, {(SCORE_BITS-1){1'b0}}};
	assign new_pos = tks_pkg::POS_W'(seen_q);

	// fill and drop state after this beat
	assign filled_next  = (take_score && (filled_q < FW'(K_MAX))) ? filled_q + FW'(1)
	                                                                 : filled_q;
	assign dropped_next = dropped_q || (accept && !take_score);

	// number of results: min(clamped k, kept entries)
	assign k_raw    = KW'(k_count_q);
	assign k_eff    = (k_raw == '0) ? KW'(1) :
	                  (k_raw > KW'(K_MAX)) ? KW'(K_MAX) : k_raw;
	assign fill_ext = KW'(filled_next);
	assign n_out    = (fill_ext < k_eff) ? fill_ext : k_eff;

	// chain of cells, head holds the best score
	for (genvar i = 0; i < K_MAX; i++) begin : g_cell
		logic [SCORE_BITS-1:0]     p_key;
		logic [tks_pkg::POS_W-1:0] p_pos;
		logic                      p_gt;
		logic [SCORE_BITS-1:0]     n_key;
		logic [tks_pkg::POS_W-1:0] n_pos;
		logic                      s_valid;

		if (i == 0) begin : g_head
			assign p_key = new_key;
			assign p_pos = new_pos;
			assign p_gt  = 1'b0;
		end else begin : g_body
			assign p_key = key_w[i-1];
			assign p_pos = pos_w[i-1];
			assign p_gt  = gt_w[i-1];
		end

		if (i == K_MAX - 1) begin : g_tail
			assign n_key = key_w[i];
			assign n_pos = pos_w[i];
		end else begin : g_inner
			assign n_key = key_w[i+1];
			assign n_pos = pos_w[i+1];
		end

		assign s_valid = FW'(i) < filled_q;

		tks_cell #(
			.KEY_W   (SCORE_BITS),
			.IS_HEAD (i == 0)
		) u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.slot_valid (s_valid),
			.new_key    (new_key),
			.new_pos    (new_pos),
			.prev_key   (p_key),
			.prev_pos   (p_pos),
			.prev_gt    (p_gt),
			.next_key   (n_key),
			.next_pos   (n_pos),
			.key        (key_w[i]),
			.pos        (pos_w[i]),
			.gt         (gt_w[i])
		);
	end

	// k_count, run state, drain control and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k_count_q   <= 5'd1;
			filled_q    <= '0;
			seen_q      <= '0;
			dropped_q   <= 1'b0;
			draining_q  <= 1'b0;
			remain_q    <= '0;
			run_ovf_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				k_count_q <= cfg_wdata;
			end
			if (accept) begin
				if (end_of_run) begin
					filled_q   <= '0;
					seen_q     <= '0;
					dropped_q  <= 1'b0;
					draining_q <= (n_out != '0);
					remain_q   <= FW'(n_out);
					run_ovf_q  <= dropped_next;
				end else begin
					filled_q  <= filled_next;
					dropped_q <= dropped_next;
					if (take_score) begin
						seen_q <= seen_q + SW'(1);
					end
				end
			end
			if (drain_shift) begin
				out_valid_q <= 1'b1;
				remain_q    <= remain_q - FW'(1);
				if (remain_q == FW'(1)) begin
					draining_q <= 1'b0;
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (drain_shift) begin
			position_q <= pos_w[0];
			final_q    <= (remain_q == FW'(1));
			overflow_q <= run_ovf_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign position     = position_q;
	assign final_result = final_q;
	assign overflow     = overflow_q;

	// checks
	`ASSERT_CLK(a_fill_bound, clk, arst_n, filled_q <= FW'(K_MAX), "fill count past chain length")
	`ASSERT_CLK(a_seen_bound, clk, arst_n, seen_q <= SW'(N_MAX), "seen count past position limit")
	`ASSERT_CLK(a_drain_end, clk, arst_n, (drain_shift && remain_q == FW'(1)) |=> (!draining_q && out_valid_q && final_q), "drain did not end on final beat")
	`ASSERT_CLK(a_run_clear, clk, arst_n, (accept && end_of_run) |=> (filled_q == '0 && seen_q == '0 && !dropped_q), "run state not cleared at end of run")

endmodule
`default_nettype wire

// ----- bench/tks_rank_checker.sv -----
`timescale 1ns / 100ps
module tks_rank_checker (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire  [4:0]                  cfg_wdata,
	input  wire                         in_valid,
	input  wire                         in_ready,
	input  wire  signed [31:0]          score,
	input  wire                         end_of_run,
	input  wire                         out_valid,
	input  wire                         out_ready,
	input  wire  [tks_pkg::POS_W-1:0]   position,
	input  wire                         final_result,
	input  wire                         overflow,
	output int                          bad_beats,
	output int                          picks_owed
);

	localparam int K_MAX = 16;
	localparam int N_MAX = 65536;

	typedef struct packed {
		logic [tks_pkg::POS_W-1:0] pos;
		logic                      last;
		logic                      ovf;
	} pick_t;

	// predicted result beats, oldest first
	pick_t expected_picks[$];

	// shadow of the sorted chain, best score at index 0
	logic signed [31:0]        kept_score [K_MAX];
	logic [tks_pkg::POS_W-1:0] kept_pos [K_MAX];
	int                        kept_n;
	int                        seen_n;
	logic                      dropped;
	logic [4:0]                k_reg;

	pick_t got;
	pick_t want;

	// place a score below every score that is greater or equal (ties to earlier)
	task automatic rank_score(input logic signed [31:0] s, input int at);
		int slot;
		int j;
		slot = 0;
		while (slot < kept_n && s <= kept_score[slot])
			slot++;
		if (slot < K_MAX) begin
			for (j = (kept_n < K_MAX) ? kept_n : K_MAX - 1; j > slot; j--) begin
				kept_score[j] = kept_score[j-1];
				kept_pos[j]   = kept_pos[j-1];
			end
			kept_score[slot] = s;
			kept_pos[slot]   = at[tks_pkg::POS_W-1:0];
			if (kept_n < K_MAX)
				kept_n++;
		end
	endtask

	// end of run: queue min(k, kept) positions, then clear the run state
	task automatic close_run();
		int k;
		int n;
		int i;
		pick_t p;
		k = k_reg;
		if (k < 1)
			k = 1;
		if (k > K_MAX)
			k = K_MAX;
		n = (kept_n < k) ? kept_n : k;
		for (i = 0; i < n; i++) begin
			p.pos  = kept_pos[i];
			p.last = (i == n - 1);
			p.ovf  = dropped;
			expected_picks = {expected_picks, p};
		end
		kept_n  = 0;
		seen_n  = 0;
		dropped = 1'b0;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_picks.delete();
			kept_n     = 0;
			seen_n     = 0;
			dropped    = 1'b0;
			k_reg      = 5'd1;
			bad_beats  = 0;
			picks_owed = 0;
		end else begin
			if (cfg_we)
				k_reg = cfg_wdata;

			// result beat against the oldest prediction
			if (out_valid && out_ready) begin
				got = '{pos: position, last: final_result, ovf: overflow};
				if (expected_picks.size() == 0) begin
					if (bad_beats < 10)
						$display("%0t: unexpected beat pos %0d final %0b ovf %0b",
							$realtime, got.pos, got.last, got.ovf);
					bad_beats++;
				end else begin
					want = expected_picks.pop_front();
					if (got !== want) begin
						if (bad_beats < 10)
							$display("%0t: exp pos %0d final %0b ovf %0b, got pos %0d final %0b ovf %0b",
								$realtime, want.pos, want.last, want.ovf,
								got.pos, got.last, got.ovf);
						bad_beats++;
					end
				end
			end

			// score beat
			if (in_valid && in_ready) begin
				if (seen_n < N_MAX) begin
					rank_score(score, seen_n);
					seen_n++;
				end else begin
					dropped = 1'b1;
				end
				if (end_of_run)
					close_run();
			end
			picks_owed = expected_picks.size();
		end
	end

endmodule

// ----- bench/tb_top_k_score_selector_unit.sv -----
`timescale 1ns / 100ps
module tb_top_k_score_selector_unit;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int RUN_ITEMS     = 38;

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      cfg_we = 1'b0;
	logic [4:0]                cfg_wdata = '0;
	logic                      in_valid = 1'b0;
	logic                      in_ready;
	logic signed [31:0]        score = '0;
	logic                      end_of_run = 1'b0;
	logic                      out_valid;
	logic                      out_ready = 1'b0;
	logic [tks_pkg::POS_W-1:0] position;
	logic                      final_result;
	logic                      overflow;

	int   bad_beats;
	int   picks_owed;
	int   cycles = 0;
	bit   tx_gaps_on = 1'b0;
	bit   rx_stall_on = 1'b0;

	always #5 clk = ~clk;

	top_k_score_selector_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.score        (score),
		.end_of_run   (end_of_run),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.final_result (final_result),
		.overflow     (overflow)
	);

	tks_rank_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.score        (score),
		.end_of_run   (end_of_run),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.position     (position),
		.final_result (final_result),
		.overflow     (overflow),
		.bad_beats    (bad_beats),
		.picks_owed   (picks_owed)
	);

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// one score beat; called and returns at a falling edge
	task automatic push_score(input logic [31:0] s, input logic last, input int gap);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		score      <= s;
		end_of_run <= last;
		do @(posedge clk); while (in_ready !== 1'b1);
		@(negedge clk);
	endtask

	// let the result drain finish before touching k_count
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (picks_owed != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_k(input logic [4:0] v);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// mix of full-range scores, near-zero values, extremes and frequent ties
	function automatic logic [31:0] pick_score();
		case ($urandom_range(0, 5))
			3:       return $urandom_range(0, 6) - 3;
			4:       return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
			5:       return {14'h0, 2'($urandom_range(0, 3)), 16'h0};
			default: return $urandom;
		endcase
	endfunction

	function automatic int tx_gap();
		return tx_gaps_on ? $urandom_range(0, 18) : 0;
	endfunction

	// receiver: random stall before each result beat
	initial begin
		int stall;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall = rx_stall_on ? $urandom_range(0, 18) : 0;
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (out_valid !== 1'b1);
			@(negedge clk);
		end
	end

	initial begin
		int p;
		int i;
		int done;
		int run_len;
		int k_plan [8];

		k_plan = '{1, 16, 0, 31, 17, 2, 9, 15};
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed: extremes, ties at top and middle, sign boundary
		write_k(5'd16);
		push_score(32'h7FFF_FFFF, 1'b0, 0);
		push_score(32'h8000_0000, 1'b0, 1);
		push_score(32'h0000_0000, 1'b0, 0);
		push_score(32'hFFFF_FFFF, 1'b0, 2);
		push_score(32'h0000_0001, 1'b0, 0);
		push_score(32'h0005_0000, 1'b0, 0);
		push_score(32'h0005_0000, 1'b0, 3);
		push_score(32'h7FFF_FFFF, 1'b1, 0);
		wait_drained();
		// run of one score, shorter than k
		push_score(32'h8000_0000, 1'b1, 0);
		wait_drained();
		// k of zero acts as one
		write_k(5'd0);
		push_score(32'hFFFF_FFFF, 1'b0, 0);
		push_score(32'hFFFF_FFFF, 1'b0, 0);
		push_score(32'h0000_0007, 1'b1, 0);
		wait_drained();
		// k above the chain depth, run longer than the chain
		write_k(5'd31);
		for (i = 0; i < 17; i++)
			push_score(pick_score(), i == 16, 0);
		wait_drained();

		// random phases, one k setting each
		for (p = 0; p < 8; p++) begin
			tx_gaps_on  = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
			rx_stall_on = (p == 0) ? 1'b0 : (p == 1) ? 1'b1 : 1'($urandom_range(0, 3) != 0);
			write_k(p >= 5 ? 5'($urandom_range(2, 15)) : 5'(k_plan[p]));
			done = 0;
			while (done < RUN_ITEMS) begin
				run_len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3)
					: $urandom_range(4, 22);
				for (i = 0; i < run_len; i++)
					push_score(pick_score(), i == run_len - 1, tx_gap());
				done += run_len;
			end
			wait_drained();
		end

		repeat (40) @(negedge clk);
		if (bad_beats == 0 && picks_owed == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+design
design/tks_pkg.sv
design/tks_cell.sv
design/top_k_score_selector_unit.sv
bench/tks_rank_checker.sv
bench/tb_top_k_score_selector_unit.sv
